>>> rtl/mckjp_pkg.sv
// ----------------------------------------------------------------------------
// mckjp_pkg
// Shared types and constants of the bounded-jump least-cost path block:
// ring depth, field widths, sequencer state codes.
// ----------------------------------------------------------------------------
package mckjp_pkg;

	// ring depth and field widths
	localparam int MAX_JUMP    = 16;
	localparam int HEIGHT_BITS = 16;
	localparam int COST_BITS   = 32;
	localparam int JL_BITS     = 5;
	localparam int OUT_BITS    = 32;

	// ring slot index and held-position count (count reaches MAX_JUMP itself)
	localparam int RING_BITS  = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
	localparam int COUNT_BITS = $clog2(MAX_JUMP + 1);

	typedef logic [HEIGHT_BITS-1:0] height_t;
	typedef logic [COST_BITS-1:0]   cost_t;
	typedef logic [OUT_BITS-1:0]    out_cost_t;
	typedef logic [JL_BITS-1:0]     jump_limit_t;
	typedef logic [RING_BITS-1:0]   slot_t;
	typedef logic [COUNT_BITS-1:0]  count_t;

	// sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage

>>> rtl/min_cost_k_jump_path.sv
// ----------------------------------------------------------------------------
// min_cost_k_jump_path
// Least cost to reach each position of a height sequence when one jump may
// span 1 to jump_limit positions and costs the absolute height difference.
// ----------------------------------------------------------------------------
// One word in, one word out. A height word is taken when in_valid and
// in_ready are high; first = 1 opens a new sequence. The block then looks
// back over span = min(jump_limit, positions held) earlier positions, one per
// cycle through a single subtract / saturating add / compare unit that reads
// one slot of the height and cost rings each cycle. After a word is accepted,
// the block walks the look-back positions in ST_CALC, then enters ST_DONE;
// the result word rises and in_ready returns together when ST_DONE hands
// back to ST_IDLE; in_ready is low until then, and longer while a finished
// cost waits for the previous result word to be taken. The result stays in an
// output register until taken, and the next word can be accepted meanwhile.
// Costs saturate at the top of their range. jump_limit reads 0 as 1 and
// values above MAX_JUMP as MAX_JUMP; write it only while the block is idle.
// ----------------------------------------------------------------------------
module min_cost_k_jump_path (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  mckjp_pkg::jump_limit_t  cfg_wdata,
	// input words
	input  logic                    in_valid,
	output logic                    in_ready,
	input  mckjp_pkg::height_t      height,
	input  logic                    first,
	// result words
	output logic                    out_valid,
	input  logic                    out_ready,
	output mckjp_pkg::out_cost_t    cost
);
	import mckjp_pkg::*;

	state_t      state_q;
	jump_limit_t jump_limit_q;
	count_t      seen_count_q;
	slot_t       ring_head_q;
	count_t      span_q;
	count_t      j_q;
	height_t     h_q;
	cost_t       best_q;
	logic        out_valid_q;
	out_cost_t   out_cost_q;

	// history rings
	height_t     recent_heights_q [MAX_JUMP];
	cost_t       recent_costs_q   [MAX_JUMP];

	logic        in_acc;
	logic        out_free;
	count_t      limit;
	count_t      seen_eff;
	count_t      span;
	slot_t       slot;
	height_t     ph;
	height_t     diff;
	logic [COST_BITS:0] sum;
	cost_t       cand;
	logic [63:0] best_w;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign cost      = out_cost_q;
	assign out_free  = !out_valid_q || out_ready;

	// effective jump limit and look-back span for the incoming word
	always_comb begin
		if (jump_limit_q == '0) begin
			limit = COUNT_BITS'(1);
		end else if (32'(jump_limit_q) > 32'(MAX_JUMP)) begin
			limit = COUNT_BITS'(MAX_JUMP);
		end else begin
			limit = COUNT_BITS'(jump_limit_q);
		end
		seen_eff = first ? '0 : seen_count_q;
		span     = (limit < seen_eff) ? limit : seen_eff;
	end

	// shared unit: one earlier position per cycle
	always_comb begin
		slot = ring_head_q - j_q[RING_BITS-1:0];
		ph   = recent_heights_q[slot];
		diff = (h_q > ph) ? (h_q - ph) : (ph - h_q);
		sum  = {1'b0, recent_costs_q[slot]} + (COST_BITS+1)'(diff);
		cand = sum[COST_BITS] ? '1 : sum[COST_BITS-1:0];
	end

	// widened cost for the clamp to the output range
	assign best_w = 64'(best_q);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_limit_q <= JL_BITS'(1);
		end else if (cfg_we) begin
			jump_limit_q <= cfg_wdata;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seen_count_q <= '0;
			ring_head_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// result word: loaded on completion, cleared when taken
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (first) begin
							seen_count_q <= '0;
						end
						state_q <= (span == '0) ? ST_DONE : ST_CALC;
					end
				end
				ST_CALC: begin
					if (j_q == span_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						ring_head_q <= ring_head_q + 1'b1;
						if (32'(seen_count_q) < 32'(MAX_JUMP)) begin
							seen_count_q <= seen_count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers and rings
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					h_q    <= height;
					span_q <= span;
					j_q    <= COUNT_BITS'(1);
					best_q <= '0;
				end
			end
			ST_CALC: begin
				if (j_q == COUNT_BITS'(1) || cand < best_q) begin
					best_q <= cand;
				end
				j_q <= j_q + 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					recent_heights_q[ring_head_q] <= h_q;
					recent_costs_q[ring_head_q]   <= best_q;
					out_cost_q <= (best_w > 64'hFFFF_FFFF) ? '1 : best_w[OUT_BITS-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(seen_count_q) <= 32'(MAX_JUMP))
		else $error("held position count above ring depth");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> (j_q >= COUNT_BITS'(1) && j_q <= span_q))
		else $error("look-back step outside span");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word raised outside completion");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ready again right after accepting a word");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded-jump least-cost path block. A queue of
// height words feeds a clocked driver; a clocked monitor predicts each
// accepted word's path cost and compares it with the returned cost word.
// Phases vary the jump limit and the idling of both channels, and a closing
// sequence swings the height over its full range at the smallest limit.
// ----------------------------------------------------------------------------
module tb_top;
	import mckjp_pkg::*;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = MAX_JUMP + 6;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS   = 224;
	localparam int SWING_WORDS   = 40;
	localparam int NO_HOLD       = -1;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
	typedef enum logic [1:0] {HS_UNIFORM, HS_WALK, HS_EXTREME, HS_NARROW} height_style_t;

	typedef struct {
		height_t h;
		logic    first;
		logic    hold;
	} height_word_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	jump_limit_t cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	height_t     height    = '0;
	logic        first     = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_cost_t   cost;

	// stimulus and expectation stores
	height_word_t pending_words[$];
	out_cost_t    expected_costs[$];
	height_word_t drive_word;
	out_cost_t    want_cost;
	logic         in_taken = 1'b0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;
	int errors         = 0;
	int words_sent     = 0;
	int results_checked = 0;
	int saturated_seen = 0;
	int settings_used  = 0;
	int phases_run     = 0;

	// predictor state: rings of recent heights and path costs
	height_t     path_heights[MAX_JUMP] = '{default: '0};
	cost_t       path_costs[MAX_JUMP]   = '{default: '0};
	int          held_count    = 0;
	slot_t       next_slot     = '0;
	jump_limit_t limit_setting = 5'd1;

	min_cost_k_jump_path dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.height    (height),
		.first     (first),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cost      (cost)
	);

	always #5 clk = ~clk;

	// least cost to reach this position, updating the rings
	function automatic out_cost_t predict_path_cost(height_t h, logic is_first);
		int                 lim;
		int                 span;
		int                 j;
		slot_t              slot;
		height_t            diff;
		logic [COST_BITS:0] total;
		cost_t              best;
		logic               found;
		if (is_first)
			held_count = 0;
		lim = int'(limit_setting);
		if (lim == 0)
			lim = 1;
		if (lim > MAX_JUMP)
			lim = MAX_JUMP;
		span = (lim < held_count) ? lim : held_count;
		best = '0;
		found = 1'b0;
		for (j = 1; j <= span; j++) begin
			slot = slot_t'((int'(next_slot) + MAX_JUMP - j) % MAX_JUMP);
			diff = (h > path_heights[slot]) ? h - path_heights[slot] : path_heights[slot] - h;
			total = path_costs[slot] + diff;
			if (total[COST_BITS])
				total = {1'b0, {COST_BITS{1'b1}}};
			if (!found || total[COST_BITS-1:0] < best) begin
				best = total[COST_BITS-1:0];
				found = 1'b1;
			end
		end
		path_heights[next_slot] = h;
		path_costs[next_slot] = best;
		next_slot = slot_t'((int'(next_slot) + 1) % MAX_JUMP);
		if (held_count < MAX_JUMP)
			held_count++;
		return out_cost_t'(best);
	endfunction

	// cycle counter with timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d cost words outstanding",
				$time, cycle_count, expected_costs.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// monitor: predict on input handshake, check on output handshake
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && in_ready;
			if (in_taken) begin
				expected_costs.insert(expected_costs.size(), predict_path_cost(height, first));
				words_sent++;
			end
			if (out_valid && out_ready) begin
				if (expected_costs.size() == 0) begin
					errors++;
					$display("%0t: unexpected cost word, expected none, actual %0d", $time, cost);
				end else begin
					want_cost = expected_costs.pop_front();
					results_checked++;
					if (cost == '1)
						saturated_seen++;
					if (cost !== want_cost) begin
						errors++;
						$display("%0t: cost mismatch, expected %0d, actual %0d",
							$time, want_cost, cost);
					end
				end
			end
		end
	end

	// driver: present queued words, idle and stall at random
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_words.size() != 0 && int'($urandom_range(99)) >= send_idle_pct &&
				    (!pending_words[0].hold || expected_costs.size() == 0)) begin
					drive_word = pending_words.pop_front();
					in_valid <= 1'b1;
					height <= drive_word.h;
					first <= drive_word.first;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
		end
	end

	task automatic push_word(height_t h, logic f, logic hold);
		height_word_t w;
		w.h = h;
		w.first = f;
		w.hold = hold;
		pending_words.insert(pending_words.size(), w);
	endtask

	// block quiet: nothing queued, nothing presented, nothing outstanding
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || in_valid || expected_costs.size() != 0);
	endtask

	task automatic write_limit(jump_limit_t v);
		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		limit_setting = v;
		settings_used++;
	endtask

	task automatic set_idle_mode(idle_mode_t mode);
		case (mode)
			IDLE_SEND: begin
				send_idle_pct = 46;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 46;
			end
			IDLE_BOTH: begin
				send_idle_pct = 13;
				recv_stall_pct = 13;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
		phases_run++;
	endtask

	// sequences of random length and height style, a few broken openings
	task automatic add_random_sequences(int count, int hold_at);
		int            made;
		int            len;
		int            k;
		height_style_t style;
		height_t       h;
		logic          f;
		made = 0;
		while (made < count) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30);
			style = height_style_t'($urandom_range(3));
			h = height_t'($urandom);
			for (k = 0; k < len && made < count; k++) begin
				case (style)
					HS_UNIFORM: h = height_t'($urandom);
					HS_WALK:    h = h + height_t'($urandom_range(64)) - height_t'(32);
					HS_EXTREME: h = $urandom_range(1) ? '1 : '0;
					default:    h = height_t'($urandom_range(15));
				endcase
				if (k == 0)
					f = ($urandom_range(19) != 0);
				else
					f = ($urandom_range(49) == 0);
				push_word(h, f, (made == hold_at) || ($urandom_range(299) == 0));
				made++;
			end
		end
	endtask

	// phase sequencing
	initial begin
		height_t     climb[14];
		jump_limit_t limits[RANDOM_PHASES];
		int          p;
		int          k;
		climb = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hFFFE, 16'h7FFF,
			16'h0100, 16'hFFFF, 16'h1234, 16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00};
		limits = '{5'd16, 5'd17, 5'd1, jump_limit_t'($urandom_range(2, 15)), 5'd0, 5'd31,
			jump_limit_t'($urandom_range(31)), jump_limit_t'($urandom_range(1, 16))};
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset limit, words before any opening flag, restart mid-sequence
		set_idle_mode(IDLE_NONE);
		push_word(16'h1234, 1'b0, 1'b0);
		push_word(16'hFFFF, 1'b0, 1'b0);
		push_word(16'h0000, 1'b0, 1'b0);
		push_word(16'hFFFF, 1'b1, 1'b0);
		push_word(16'h0000, 1'b0, 1'b0);

		// zero limit acts as one
		write_limit(5'd0);
		push_word(16'h0000, 1'b1, 1'b0);
		push_word(16'hAAAA, 1'b0, 1'b0);
		push_word(16'h5555, 1'b0, 1'b0);
		push_word(16'h0000, 1'b0, 1'b0);

		// limit above the ring depth, short history growing
		write_limit(5'd31);
		for (k = 0; k < 14; k++)
			push_word(climb[k], k == 0, 1'b0);

		// random phases over limits and idling patterns
		for (p = 0; p < RANDOM_PHASES; p++) begin
			write_limit(limits[p]);
			set_idle_mode(idle_mode_t'(p % 4));
			add_random_sequences(PHASE_WORDS, (p == 2) ? 100 : NO_HOLD);
		end

		// one sequence of full-range swings at the smallest limit
		write_limit(5'd1);
		set_idle_mode(IDLE_NONE);
		for (k = 0; k < SWING_WORDS; k++)
			push_word((k % 2 == 0) ? 16'h0000 : 16'hFFFF, k == 0, 1'b0);

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d height words over %0d phases and %0d jump-limit writes",
			words_sent, phases_run, settings_used);
		$display("%0d cost words checked, %0d of them saturated, %0d errors",
			results_checked, saturated_seen, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
